// ----- rtl/rrts_pkg.sv -----
// shared types and constants of the round-robin thread scheduler
package rrts_pkg;

   localparam int MAX_THREADS = 16;
   localparam int SLOT_W      = $clog2(MAX_THREADS);
   localparam int CNT_W       = $clog2(MAX_THREADS + 1);
   localparam int OP_W        = 3;
   localparam int STATUS_W    = 3;
   localparam int SLOT_FLD_W  = 4;

   typedef enum logic [1:0] {
      SLOT_FREE    = 2'd0,
      SLOT_READY   = 2'd1,
      SLOT_BLOCKED = 2'd2,
      SLOT_RUNNING = 2'd3
   } slot_state_type;

   typedef enum logic [OP_W-1:0] {
      OP_CREATE  = 3'd0,
      OP_START   = 3'd1,
      OP_YIELD   = 3'd2,
      OP_BLOCK   = 3'd3,
      OP_FINISH  = 3'd4,
      OP_UNBLOCK = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK          = 3'd0,
      STATUS_ALL_DONE    = 3'd1,
      STATUS_DEADLOCK    = 3'd2,
      STATUS_FULL        = 3'd3,
      STATUS_NOT_BLOCKED = 3'd4,
      STATUS_NO_RUNNING  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      HALT_NONE     = 2'd0,
      HALT_ALL_DONE = 2'd1,
      HALT_DEADLOCK = 2'd2
   } halt_type;

endpackage

// ----- rtl/rrts_if.sv -----
// request and response channel interfaces of the scheduler

interface rrts_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] operation;
   logic [3:0] target_slot;

   modport source (output valid, output operation, output target_slot, input ready);
   modport sink   (input valid, input operation, input target_slot, output ready);
endinterface

interface rrts_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [3:0] slot;

   modport source (output valid, output status, output slot, input ready);
   modport sink   (input valid, input status, input slot, output ready);
endinterface

// ----- rtl/round_robin_thread_scheduler.sv -----
// a request passes through the input register, then the result register, to the response
// one request per cycle unless stalled; slot table update and queue pop share one cycle
// a response held by the sink stalls the input register, and a request is still taken
//   while the input register is empty or draining
// reset (synchronous, active high) frees all slots, empties the ready queue, clears the
//   running thread and the halt status; queue entries themselves are not cleared
module round_robin_thread_scheduler import rrts_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   rrts_req_if.sink  req_ch,
   rrts_rsp_if.source rsp_ch
);

   // input register
   logic                  in_valid_ff;
   logic [OP_W-1:0]       op_ff;
   logic [3:0]            target_ff;

   // result register
   logic                  rsp_valid_ff;
   status_type            status_ff;
   logic [SLOT_FLD_W-1:0] slot_ff;

   // scheduler state
   slot_state_type        slot_state_ff [MAX_THREADS];
   slot_state_type        slot_state_in [MAX_THREADS];
   logic [SLOT_W-1:0]     fifo_ff [MAX_THREADS];
   logic [SLOT_W-1:0]     head_ff, head_in;
   logic [SLOT_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [SLOT_W-1:0]     running_ff, running_in;
   logic                  has_run_ff, has_run_in;
   halt_type              halt_ff, halt_in;

   // per-request work signals
   logic                  fire;
   logic                  push_en;
   logic [SLOT_W-1:0]     push_val;
   logic                  pop_en;
   logic [SLOT_W-1:0]     pop_val;
   logic                  do_dispatch;
   logic                  any_blocked;
   logic                  free_found;
   logic [SLOT_W-1:0]     free_idx;
   logic [SLOT_W+3:0]     tgt_ext;
   logic                  tgt_in_range;
   logic [SLOT_W-1:0]     tgt_idx;
   logic [SLOT_W-1:0]     cur_slot;
   status_type            status_in;
   logic [SLOT_W-1:0]     slot_in;

   function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] p);
      if (p == SLOT_W'(MAX_THREADS - 1)) begin
         return '0;
      end
      return p + SLOT_W'(1);
   endfunction

   function automatic logic [SLOT_FLD_W-1:0] to_field(input logic [SLOT_W-1:0] s);
      logic [SLOT_W+3:0] ext;
      ext = {4'b0000, s};
      return ext[SLOT_FLD_W-1:0];
   endfunction

   // handshake
   assign fire         = in_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || fire;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.status = status_ff;
   assign rsp_ch.slot   = slot_ff;

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
      if (req_ch.valid && req_ch.ready) begin
         op_ff     <= req_ch.operation;
         target_ff <= req_ch.target_slot;
      end
   end

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MAX_THREADS - 1; i >= 0; i--) begin
         if (slot_state_ff[i] == SLOT_FREE) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   // unblock target decode
   assign tgt_ext      = {SLOT_W'(0), target_ff};
   assign tgt_in_range = tgt_ext < (SLOT_W + 4)'(MAX_THREADS);
   assign tgt_idx      = tgt_ext[SLOT_W-1:0];
   assign cur_slot     = has_run_ff ? running_ff : '0;

   // operation decode and slot table update
   always_comb begin
      slot_state_in = slot_state_ff;
      push_en       = 1'b0;
      push_val      = '0;
      do_dispatch   = 1'b0;
      status_in     = STATUS_OK;
      slot_in       = cur_slot;
      if (halt_ff != HALT_NONE) begin
         status_in = status_type'({1'b0, halt_ff});
         slot_in   = '0;
      end else begin
         case (op_ff)
            OP_CREATE: begin
               if (free_found) begin
                  slot_state_in[free_idx] = SLOT_READY;
                  push_en  = 1'b1;
                  push_val = free_idx;
                  slot_in  = free_idx;
               end else begin
                  status_in = STATUS_FULL;
                  slot_in   = '0;
               end
            end
            OP_START: begin
               do_dispatch = !has_run_ff;
            end
            OP_YIELD, OP_BLOCK, OP_FINISH: begin
               if (!has_run_ff) begin
                  status_in = STATUS_NO_RUNNING;
                  slot_in   = '0;
               end else begin
                  do_dispatch = 1'b1;
                  if (op_ff == OP_YIELD) begin
                     slot_state_in[running_ff] = SLOT_READY;
                     push_en  = 1'b1;
                     push_val = running_ff;
                  end else if (op_ff == OP_BLOCK) begin
                     slot_state_in[running_ff] = SLOT_BLOCKED;
                  end else begin
                     slot_state_in[running_ff] = SLOT_FREE;
                  end
               end
            end
            OP_UNBLOCK: begin
               if (tgt_in_range && slot_state_ff[tgt_idx] == SLOT_BLOCKED) begin
                  slot_state_in[tgt_idx] = SLOT_READY;
                  push_en  = 1'b1;
                  push_val = tgt_idx;
               end else begin
                  status_in = STATUS_NOT_BLOCKED;
                  slot_in   = '0;
               end
            end
            default: begin
               status_in = STATUS_OK;
            end
         endcase
      end

      // blocked scan on the updated table
      any_blocked = 1'b0;
      for (int i = 0; i < MAX_THREADS; i++) begin
         if (slot_state_in[i] == SLOT_BLOCKED) begin
            any_blocked = 1'b1;
         end
      end

      // dispatch: run the queue head or halt
      pop_en     = 1'b0;
      pop_val    = (count_ff == '0) ? push_val : fifo_ff[head_ff];
      running_in = running_ff;
      has_run_in = has_run_ff;
      halt_in    = halt_ff;
      if (do_dispatch) begin
         if (count_ff != '0 || push_en) begin
            pop_en                 = 1'b1;
            slot_state_in[pop_val] = SLOT_RUNNING;
            running_in             = pop_val;
            has_run_in             = 1'b1;
            status_in              = STATUS_OK;
            slot_in                = pop_val;
         end else begin
            running_in = '0;
            has_run_in = 1'b0;
            halt_in    = any_blocked ? HALT_DEADLOCK : HALT_ALL_DONE;
            status_in  = any_blocked ? STATUS_DEADLOCK : STATUS_ALL_DONE;
            slot_in    = '0;
         end
      end
   end

   // queue pointers
   always_comb begin
      head_in  = pop_en ? wrap_inc(head_ff) : head_ff;
      tail_in  = push_en ? wrap_inc(tail_ff) : tail_ff;
      count_in = count_ff + CNT_W'(push_en) - CNT_W'(pop_en);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_THREADS; i++) begin
            slot_state_ff[i] <= SLOT_FREE;
         end
         head_ff    <= '0;
         tail_ff    <= '0;
         count_ff   <= '0;
         running_ff <= '0;
         has_run_ff <= 1'b0;
         halt_ff    <= HALT_NONE;
      end else if (fire) begin
         slot_state_ff <= slot_state_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         running_ff    <= running_in;
         has_run_ff    <= has_run_in;
         halt_ff       <= halt_in;
      end
   end

   // ready queue entries
   always_ff @(posedge clock) begin
      if (fire && push_en) begin
         fifo_ff[tail_ff] <= push_val;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fire) begin
         status_ff <= status_in;
         slot_ff   <= to_field(slot_in);
      end
   end

endmodule

// ----- rtl/rrts_checker.sv -----
// port-level checker of the scheduler and its bind
module rrts_checker import rrts_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [3:0] rsp_slot
);

   logic       halted_ff;
   logic [2:0] halt_status_ff;
   logic [1:0] pending_ff;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid && req_ready;
   assign rsp_take = rsp_valid && rsp_ready;

   // track halt report and requests still owed a response
   always_ff @(posedge clock) begin
      if (reset) begin
         halted_ff      <= 1'b0;
         halt_status_ff <= STATUS_OK;
         pending_ff     <= '0;
      end else begin
         if (rsp_take && !halted_ff &&
             (rsp_status == STATUS_ALL_DONE || rsp_status == STATUS_DEADLOCK)) begin
            halted_ff      <= 1'b1;
            halt_status_ff <= rsp_status;
         end
         pending_ff <= pending_ff + 2'(req_take) - 2'(rsp_take);
      end
   end

   // once halted, every response repeats the halt status
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && halted_ff |-> rsp_status == halt_status_ff)
      else $error("halt status not repeated");

   // error and halt responses carry slot zero
   a_err_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |-> rsp_slot == 4'd0)
      else $error("non-ok response with nonzero slot");

   // no response without an accepted request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> pending_ff != 2'd0)
      else $error("response without request");

   // a stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind round_robin_thread_scheduler rrts_checker u_rrts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_status (rsp_ch.status),
   .rsp_slot   (rsp_ch.slot)
);
